/* rtl/macd_pkg.sv */
// Package for the MACD indicator stream: widths, register indexes, reset values and types.
`default_nettype none

package macd_pkg;

   // Price and result format.
   localparam int SAMPLE_WIDTH = 32;

   // Smoothing factors are unsigned Q1.16.
   localparam int ALPHA_FRAC  = 16;
   localparam int ALPHA_WIDTH = ALPHA_FRAC + 1;
   localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE = ALPHA_WIDTH'(1) << ALPHA_FRAC;

   // Sample counter and warm-up register.
   localparam int COUNT_WIDTH = 12;

   // Arithmetic widths of the shared EMA unit.
   localparam int DIFF_WIDTH = SAMPLE_WIDTH + 1;
   localparam int PROD_WIDTH = DIFF_WIDTH + ALPHA_WIDTH + 1;
   localparam int SUM_WIDTH  = PROD_WIDTH - ALPHA_FRAC + 1;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = ALPHA_WIDTH;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SHORT_ALPHA  = 2'd0,
      CSR_LONG_ALPHA   = 2'd1,
      CSR_SIGNAL_ALPHA = 2'd2,
      CSR_WARMUP_INDEX = 2'd3
   } csr_index_type;

   localparam logic [ALPHA_WIDTH-1:0] SHORT_ALPHA_RESET  = ALPHA_WIDTH'(9830);
   localparam logic [ALPHA_WIDTH-1:0] LONG_ALPHA_RESET   = ALPHA_WIDTH'(4915);
   localparam logic [ALPHA_WIDTH-1:0] SIGNAL_ALPHA_RESET = ALPHA_WIDTH'(13107);
   localparam logic [COUNT_WIDTH-1:0] WARMUP_RESET       = COUNT_WIDTH'(25);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_MUL_SHORT = 9'b000000010,
      ST_ADD_SHORT = 9'b000000100,
      ST_MUL_LONG  = 9'b000001000,
      ST_ADD_LONG  = 9'b000010000,
      ST_MACD      = 9'b000100000,
      ST_MUL_SIG   = 9'b001000000,
      ST_ADD_SIG   = 9'b010000000,
      ST_EMIT      = 9'b100000000
   } state_type;

   // Clamps a wide signed value into the sample range.
   function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
      input logic signed [SUM_WIDTH-1:0] v
   );
      logic signed [SUM_WIDTH-1:0] hi;
      logic signed [SUM_WIDTH-1:0] lo;
      hi = '0;
      hi[SAMPLE_WIDTH-2:0] = '1;
      lo = '1;
      lo[SAMPLE_WIDTH-2:0] = '0;
      if (v > hi) begin
         sat_sample = hi[SAMPLE_WIDTH-1:0];
      end else if (v < lo) begin
         sat_sample = lo[SAMPLE_WIDTH-1:0];
      end else begin
         sat_sample = v[SAMPLE_WIDTH-1:0];
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/macd_indicator_stream.sv */
// Top level of the MACD indicator stream: sequencer, shared EMA unit and state.
`default_nettype none

// MACD indicator over a stream of signed Q16.16 prices. A transfer with
// series_start set seeds the short and long averages with its price and
// gives no result; the block stays idle and ready. Every other sample updates both
// averages and forms the MACD line; samples before the warm-up index give
// no result and keep the block busy through the short and long EMA steps and
// the MACD step. From the warm-up index on, each sample also updates the signal
// average and gives one result (MACD, signal, histogram), and a new sample is
// not taken until the block is through with the last one. The pace is
// set by the single multiplier and adder pair that all three EMA updates
// share, one multiply step and one accumulate step per average. The result
// sits in an output register, so a stalled result does not hold off the
// next sample until that sample's own result is ready.
module macd_indicator_stream (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          req_valid,
   output logic                                         req_ready,
   input  wire  signed [macd_pkg::SAMPLE_WIDTH-1:0]     req_price_sample,
   input  wire                                          req_series_start,
   output logic                                         rsp_valid,
   input  wire                                          rsp_ready,
   output logic signed [macd_pkg::SAMPLE_WIDTH-1:0]     rsp_macd_value,
   output logic signed [macd_pkg::SAMPLE_WIDTH-1:0]     rsp_signal_value,
   output logic signed [macd_pkg::SAMPLE_WIDTH-1:0]     rsp_hist_value,
   input  wire                                          csr_write,
   input  wire         [macd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire         [macd_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int SW = macd_pkg::SAMPLE_WIDTH;
   localparam int AW = macd_pkg::ALPHA_WIDTH;
   localparam int CW = macd_pkg::COUNT_WIDTH;
   localparam int DW = macd_pkg::DIFF_WIDTH;
   localparam int PW = macd_pkg::PROD_WIDTH;
   localparam int UW = macd_pkg::SUM_WIDTH;
   localparam int AF = macd_pkg::ALPHA_FRAC;

   // Configuration registers.
   logic [AW-1:0] short_alpha_ff, short_alpha_in;
   logic [AW-1:0] long_alpha_ff, long_alpha_in;
   logic [AW-1:0] signal_alpha_ff, signal_alpha_in;
   logic [CW-1:0] warmup_ff, warmup_in;

   // Sequencer and series state.
   macd_pkg::state_type state_ff, state_in;
   logic signed [SW-1:0] sample_ff, sample_in;
   logic signed [SW-1:0] short_avg_ff, short_avg_in;
   logic signed [SW-1:0] long_avg_ff, long_avg_in;
   logic signed [SW-1:0] signal_avg_ff, signal_avg_in;
   logic signed [SW-1:0] macd_ff, macd_in;
   logic [CW-1:0]        count_ff, count_in;
   logic signed [PW-1:0] prod_ff, prod_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0] rsp_macd_ff, rsp_macd_in;
   logic signed [SW-1:0] rsp_signal_ff, rsp_signal_in;
   logic signed [SW-1:0] rsp_hist_ff, rsp_hist_in;

   // Shared unit signals.
   logic signed [SW-1:0] op_x;
   logic signed [SW-1:0] op_avg;
   logic [AW-1:0]        op_alpha_raw;
   logic [AW-1:0]        op_alpha;
   logic signed [DW-1:0] mul_diff;
   logic signed [PW-1:0] rnd_sum;
   logic signed [UW-1:0] acc_sum;
   logic signed [SW-1:0] acc_sat;
   logic signed [SW-1:0] sub_a;
   logic signed [SW-1:0] sub_b;
   logic signed [SW-1:0] sub_sat;
   logic [CW-1:0]        warm;
   logic [CW-1:0]        count_next;
   logic                 req_xfer;
   logic                 out_free;

   assign req_ready = (state_ff == macd_pkg::ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign warm      = (warmup_ff == '0) ? CW'(1) : warmup_ff;
   assign count_next = count_ff + CW'(1);

   // Operand selection for the shared multiply and accumulate.
   always_comb begin
      op_x         = sample_ff;
      op_avg       = short_avg_ff;
      op_alpha_raw = short_alpha_ff;
      if (state_ff inside {macd_pkg::ST_MUL_LONG, macd_pkg::ST_ADD_LONG}) begin
         op_avg       = long_avg_ff;
         op_alpha_raw = long_alpha_ff;
      end else if (state_ff inside {macd_pkg::ST_MUL_SIG, macd_pkg::ST_ADD_SIG}) begin
         op_x         = macd_ff;
         op_avg       = signal_avg_ff;
         op_alpha_raw = signal_alpha_ff;
      end
   end

   // A factor above one acts as exactly one.
   assign op_alpha = (op_alpha_raw > macd_pkg::ALPHA_ONE) ? macd_pkg::ALPHA_ONE : op_alpha_raw;

   assign mul_diff = DW'(op_x) - DW'(op_avg);
   assign prod_in  = $signed({{(PW-DW){mul_diff[DW-1]}}, mul_diff})
                   * $signed({{(PW-AW){1'b0}}, op_alpha});

   // Round half up: add one half, then floor by the arithmetic shift.
   assign rnd_sum = prod_ff + (PW'(1) <<< (AF-1));
   assign acc_sum = UW'(op_avg) + UW'($signed(rnd_sum[PW-1:AF]));
   assign acc_sat = macd_pkg::sat_sample(acc_sum);

   // Saturating subtract shared by the MACD line and the histogram.
   always_comb begin
      sub_a = short_avg_ff;
      sub_b = long_avg_ff;
      if (state_ff == macd_pkg::ST_EMIT) begin
         sub_a = macd_ff;
         sub_b = signal_avg_ff;
      end
   end
   assign sub_sat = macd_pkg::sat_sample(UW'(sub_a) - UW'(sub_b));

   // Configuration writes.
   always_comb begin
      short_alpha_in  = short_alpha_ff;
      long_alpha_in   = long_alpha_ff;
      signal_alpha_in = signal_alpha_ff;
      warmup_in       = warmup_ff;
      if (csr_write) begin
         case (macd_pkg::csr_index_type'(csr_index))
            macd_pkg::CSR_SHORT_ALPHA:  short_alpha_in  = csr_wdata;
            macd_pkg::CSR_LONG_ALPHA:   long_alpha_in   = csr_wdata;
            macd_pkg::CSR_SIGNAL_ALPHA: signal_alpha_in = csr_wdata;
            macd_pkg::CSR_WARMUP_INDEX: warmup_in       = csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      sample_in     = sample_ff;
      short_avg_in  = short_avg_ff;
      long_avg_in   = long_avg_ff;
      signal_avg_in = signal_avg_ff;
      macd_in       = macd_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_macd_in   = rsp_macd_ff;
      rsp_signal_in = rsp_signal_ff;
      rsp_hist_in   = rsp_hist_ff;
      case (state_ff)
         macd_pkg::ST_IDLE: begin
            if (req_xfer) begin
               sample_in = req_price_sample;
               if (req_series_start) begin
                  short_avg_in  = req_price_sample;
                  long_avg_in   = req_price_sample;
                  signal_avg_in = '0;
                  count_in      = '0;
               end else begin
                  state_in = macd_pkg::ST_MUL_SHORT;
               end
            end
         end
         macd_pkg::ST_MUL_SHORT: state_in = macd_pkg::ST_ADD_SHORT;
         macd_pkg::ST_ADD_SHORT: begin
            short_avg_in = acc_sat;
            state_in     = macd_pkg::ST_MUL_LONG;
         end
         macd_pkg::ST_MUL_LONG: state_in = macd_pkg::ST_ADD_LONG;
         macd_pkg::ST_ADD_LONG: begin
            long_avg_in = acc_sat;
            state_in    = macd_pkg::ST_MACD;
         end
         macd_pkg::ST_MACD: begin
            macd_in  = sub_sat;
            state_in = macd_pkg::ST_MUL_SIG;
            if (count_ff < warm) begin
               count_in = count_next;
               if (count_next != warm) begin
                  state_in = macd_pkg::ST_IDLE;
               end else begin
                  // The warm-up sample seeds the signal average with the MACD line.
                  signal_avg_in = sub_sat;
               end
            end
         end
         macd_pkg::ST_MUL_SIG: state_in = macd_pkg::ST_ADD_SIG;
         macd_pkg::ST_ADD_SIG: begin
            signal_avg_in = acc_sat;
            state_in      = macd_pkg::ST_EMIT;
         end
         macd_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_macd_in   = macd_ff;
               rsp_signal_in = signal_avg_ff;
               rsp_hist_in   = sub_sat;
               state_in      = macd_pkg::ST_IDLE;
            end
         end
         default: state_in = macd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_alpha_ff  <= macd_pkg::SHORT_ALPHA_RESET;
         long_alpha_ff   <= macd_pkg::LONG_ALPHA_RESET;
         signal_alpha_ff <= macd_pkg::SIGNAL_ALPHA_RESET;
         warmup_ff       <= macd_pkg::WARMUP_RESET;
         state_ff        <= macd_pkg::ST_IDLE;
         short_avg_ff    <= '0;
         long_avg_ff     <= '0;
         signal_avg_ff   <= '0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         short_alpha_ff  <= short_alpha_in;
         long_alpha_ff   <= long_alpha_in;
         signal_alpha_ff <= signal_alpha_in;
         warmup_ff       <= warmup_in;
         state_ff        <= state_in;
         short_avg_ff    <= short_avg_in;
         long_avg_ff     <= long_avg_in;
         signal_avg_ff   <= signal_avg_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      macd_ff       <= macd_in;
      prod_ff       <= prod_in;
      rsp_macd_ff   <= rsp_macd_in;
      rsp_signal_ff <= rsp_signal_in;
      rsp_hist_ff   <= rsp_hist_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_macd_value   = rsp_macd_ff;
   assign rsp_signal_value = rsp_signal_ff;
   assign rsp_hist_value   = rsp_hist_ff;

   // A result only appears when the sequencer leaves the emit step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == macd_pkg::ST_EMIT))
      else $error("result appeared without an emit step");

   // A sample that continues a series always starts with the short EMA multiply.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_series_start |=> state_ff == macd_pkg::ST_MUL_SHORT)
      else $error("sample transfer did not start the EMA sequence");

   // A series start seeds both averages alike and clears the signal average.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_series_start
      |=> short_avg_ff == long_avg_ff && signal_avg_ff == '0 && count_ff == '0)
      else $error("series start did not seed the averages");

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the MACD indicator stream with its own EMA predictor.
`timescale 1ns / 1ps

module tb;

   localparam int SAMPLE_WIDTH   = macd_pkg::SAMPLE_WIDTH;
   localparam int ALPHA_WIDTH    = macd_pkg::ALPHA_WIDTH;
   localparam int ALPHA_FRAC     = macd_pkg::ALPHA_FRAC;
   localparam int COUNT_WIDTH    = macd_pkg::COUNT_WIDTH;
   localparam int CSR_DATA_WIDTH = macd_pkg::CSR_DATA_WIDTH;

   localparam int RESET_CYCLES = 8;
   localparam int DRAIN_CYCLES = 16;
   localparam int STALL_LIMIT  = 1000;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] macd;
      logic signed [SAMPLE_WIDTH-1:0] signal;
      logic signed [SAMPLE_WIDTH-1:0] hist;
   } indicator_type;

   typedef enum int {
      RDY_ALWAYS,
      RDY_RANDOM,
      RDY_EVERY_THIRD,
      RDY_BLOCKED
   } ready_mode_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [SAMPLE_WIDTH-1:0] req_price_sample = '0;
   logic                           req_series_start = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_macd_value;
   logic signed [SAMPLE_WIDTH-1:0] rsp_signal_value;
   logic signed [SAMPLE_WIDTH-1:0] rsp_hist_value;
   logic                           csr_write = 1'b0;
   macd_pkg::csr_index_type        csr_index = macd_pkg::CSR_SHORT_ALPHA;
   logic [CSR_DATA_WIDTH-1:0]      csr_wdata = '0;

   // Predictor copy of the configuration and of the averaging state.
   logic [ALPHA_WIDTH-1:0]         cfg_short_alpha  = macd_pkg::SHORT_ALPHA_RESET;
   logic [ALPHA_WIDTH-1:0]         cfg_long_alpha   = macd_pkg::LONG_ALPHA_RESET;
   logic [ALPHA_WIDTH-1:0]         cfg_signal_alpha = macd_pkg::SIGNAL_ALPHA_RESET;
   logic [COUNT_WIDTH-1:0]         cfg_warmup       = macd_pkg::WARMUP_RESET;
   logic signed [SAMPLE_WIDTH-1:0] pred_short  = '0;
   logic signed [SAMPLE_WIDTH-1:0] pred_long   = '0;
   logic signed [SAMPLE_WIDTH-1:0] pred_signal = '0;
   logic [COUNT_WIDTH-1:0]         samples_seen = '0;

   indicator_type                  predicted_indicators[$];
   int                             error_count = 0;
   int                             idle_cycles = 0;
   int                             burst_left = 0;
   logic signed [SAMPLE_WIDTH-1:0] last_price = '0;

   ready_mode_type                 ready_mode = RDY_ALWAYS;
   int                             ready_left = 0;
   int                             ready_phase = 0;

   macd_indicator_stream dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_price_sample (req_price_sample),
      .req_series_start (req_series_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_macd_value   (rsp_macd_value),
      .rsp_signal_value (rsp_signal_value),
      .rsp_hist_value   (rsp_hist_value),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic signed [SAMPLE_WIDTH-1:0] clamp_sample(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return hi[SAMPLE_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[SAMPLE_WIDTH-1:0];
      end
      return v[SAMPLE_WIDTH-1:0];
   endfunction

   // Moves avg toward x by alpha in Q1.16, rounding half toward plus infinity.
   function automatic logic signed [SAMPLE_WIDTH-1:0] ema_update(
      input logic signed [SAMPLE_WIDTH-1:0] avg,
      input logic signed [SAMPLE_WIDTH-1:0] x,
      input logic [ALPHA_WIDTH-1:0]         alpha
   );
      longint factor;
      longint prod;
      longint delta;
      factor = longint'(alpha);
      if (factor > longint'(macd_pkg::ALPHA_ONE)) begin
         factor = longint'(macd_pkg::ALPHA_ONE);
      end
      prod  = (longint'(x) - longint'(avg)) * factor;
      delta = (prod + (longint'(1) <<< (ALPHA_FRAC - 1))) >>> ALPHA_FRAC;
      return clamp_sample(longint'(avg) + delta);
   endfunction

   task automatic predict_indicators(
      input logic signed [SAMPLE_WIDTH-1:0] price,
      input logic                           start
   );
      logic [COUNT_WIDTH-1:0]         warm;
      logic signed [SAMPLE_WIDTH-1:0] macd;
      indicator_type                  item;
      bit                             emit;
      warm = (cfg_warmup == '0) ? COUNT_WIDTH'(1) : cfg_warmup;
      if (start) begin
         pred_short   = price;
         pred_long    = price;
         pred_signal  = '0;
         samples_seen = '0;
      end else begin
         pred_short = ema_update(pred_short, price, cfg_short_alpha);
         pred_long  = ema_update(pred_long, price, cfg_long_alpha);
         macd       = clamp_sample(longint'(pred_short) - longint'(pred_long));
         emit       = 1'b1;
         if (samples_seen < warm) begin
            samples_seen = samples_seen + 1'b1;
            if (samples_seen != warm) begin
               emit = 1'b0;
            end else begin
               // The signal average is seeded with the MACD line at warm-up.
               pred_signal = macd;
            end
         end
         if (emit) begin
            pred_signal = ema_update(pred_signal, macd, cfg_signal_alpha);
            item.macd   = macd;
            item.signal = pred_signal;
            item.hist   = clamp_sample(longint'(macd) - longint'(pred_signal));
            predicted_indicators.push_back(item);
         end
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_sample(
      input logic signed [SAMPLE_WIDTH-1:0] price,
      input logic                           start
   );
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_price_sample <= price;
      req_series_start <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_indicators(price, start);
      last_price = price;
      @(negedge clock);
   endtask

   task automatic write_csr(input macd_pkg::csr_index_type idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         macd_pkg::CSR_SHORT_ALPHA:  cfg_short_alpha  = data;
         macd_pkg::CSR_LONG_ALPHA:   cfg_long_alpha   = data;
         macd_pkg::CSR_SIGNAL_ALPHA: cfg_signal_alpha = data;
         macd_pkg::CSR_WARMUP_INDEX: cfg_warmup       = data[COUNT_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(
      input logic [ALPHA_WIDTH-1:0]    short_a,
      input logic [ALPHA_WIDTH-1:0]    long_a,
      input logic [ALPHA_WIDTH-1:0]    signal_a,
      input logic [CSR_DATA_WIDTH-1:0] warm_data
   );
      write_csr(macd_pkg::CSR_SHORT_ALPHA, short_a);
      write_csr(macd_pkg::CSR_LONG_ALPHA, long_a);
      write_csr(macd_pkg::CSR_SIGNAL_ALPHA, signal_a);
      write_csr(macd_pkg::CSR_WARMUP_INDEX, warm_data);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Waits for every predicted result, then lets a sample without a result finish.
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (predicted_indicators.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic signed [SAMPLE_WIDTH-1:0] walk_price(
      input logic signed [SAMPLE_WIDTH-1:0] prev
   );
      longint p;
      if ($urandom_range(0, 19) == 0) begin
         return $urandom;
      end
      p = longint'(prev) + longint'($urandom_range(0, 2097152)) - longint'(1048576);
      return clamp_sample(p);
   endfunction

   function automatic logic [ALPHA_WIDTH-1:0] random_alpha();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return macd_pkg::ALPHA_ONE;
         2: return ALPHA_WIDTH'($urandom_range(65537, 131071));
         default: return ALPHA_WIDTH'($urandom_range(1, 65535));
      endcase
   endfunction

   // Prices before any series start continue from the all-zero reset state.
   task automatic test_reset_state();
      int i;
      for (i = 0; i < 27; i++) begin
         send_sample(walk_price(last_price), 1'b0);
      end
      wait_idle();
   endtask

   // Drives the MACD line into its lower saturation limit and the histogram into its upper one.
   task automatic test_saturation();
      logic signed [SAMPLE_WIDTH-1:0] max_price;
      logic signed [SAMPLE_WIDTH-1:0] min_price;
      max_price = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      min_price = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      set_config('1, '0, '0, CSR_DATA_WIDTH'(1));
      send_sample(max_price, 1'b1);
      send_sample(min_price, 1'b0);
      send_sample(max_price, 1'b0);
      send_sample('0, 1'b0);
      send_sample('1, 1'b0);
      wait_idle();
   endtask

   task automatic test_warmup_zero();
      int i;
      set_config(ALPHA_WIDTH'(32768), ALPHA_WIDTH'(16384), macd_pkg::ALPHA_ONE, '0);
      send_sample(walk_price(last_price), 1'b1);
      for (i = 0; i < 5; i++) begin
         send_sample(walk_price(last_price), 1'b0);
      end
      wait_idle();
   endtask

   // A series that has already passed a lowered warm-up index is warmed up at once.
   task automatic test_warmup_change();
      int i;
      set_config(macd_pkg::SHORT_ALPHA_RESET, macd_pkg::LONG_ALPHA_RESET,
                 macd_pkg::SIGNAL_ALPHA_RESET, CSR_DATA_WIDTH'(macd_pkg::WARMUP_RESET));
      send_sample(walk_price(last_price), 1'b1);
      for (i = 0; i < 10; i++) begin
         send_sample(walk_price(last_price), 1'b0);
      end
      wait_idle();
      set_config(macd_pkg::SHORT_ALPHA_RESET, macd_pkg::LONG_ALPHA_RESET,
                 macd_pkg::SIGNAL_ALPHA_RESET, CSR_DATA_WIDTH'(4));
      for (i = 0; i < 3; i++) begin
         send_sample(walk_price(last_price), 1'b0);
      end
      wait_idle();
      set_config(macd_pkg::SHORT_ALPHA_RESET, macd_pkg::LONG_ALPHA_RESET,
                 macd_pkg::SIGNAL_ALPHA_RESET, CSR_DATA_WIDTH'(12));
      for (i = 0; i < 4; i++) begin
         send_sample(walk_price(last_price), 1'b0);
      end
      wait_idle();
   endtask

   task automatic test_warmup_max();
      int i;
      set_config(random_alpha(), random_alpha(), random_alpha(),
                 CSR_DATA_WIDTH'({COUNT_WIDTH{1'b1}}));
      send_sample(walk_price(last_price), 1'b1);
      for (i = 0; i < 200; i++) begin
         send_sample(walk_price(last_price), 1'b0);
      end
      wait_idle();
   endtask

   task automatic test_random_series();
      int                  phase;
      int                  sent;
      int                  len;
      int                  i;
      int                  warm;
      logic [COUNT_WIDTH-1:0] warm_field;
      for (phase = 0; phase < 12; phase++) begin
         case ($urandom_range(0, 9))
            0: warm = 0;
            1: warm = 1;
            2: warm = $urandom_range(30, 80);
            default: warm = $urandom_range(2, 20);
         endcase
         warm_field = COUNT_WIDTH'(warm);
         // Bits above the warm-up field are ignored by the register.
         set_config(random_alpha(), random_alpha(), random_alpha(),
                    {CSR_DATA_WIDTH'($urandom_range(0, 31)) << COUNT_WIDTH} |
                    CSR_DATA_WIDTH'(warm_field));
         if (warm == 0) begin
            warm = 1;
         end
         sent = 0;
         while (sent < 95) begin
            // Most series are long enough to warm up; some are cut short.
            if ($urandom_range(0, 5) == 0) begin
               len = $urandom_range(0, warm);
            end else begin
               len = warm + $urandom_range(0, 30);
            end
            if ($urandom_range(0, 7) != 0) begin
               if ($urandom_range(0, 3) == 0) begin
                  send_sample($urandom, 1'b1);
               end else begin
                  send_sample(walk_price(last_price), 1'b1);
               end
               sent++;
            end
            for (i = 0; i < len; i++) begin
               send_sample(walk_price(last_price), 1'b0);
               sent++;
            end
         end
         wait_idle();
      end
   endtask

   // The receiver alternates between free flow, random stalls, a fixed pattern and blocking.
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode  = ready_mode_type'($urandom_range(0, 3));
         ready_left  = (ready_mode == RDY_BLOCKED) ? $urandom_range(1, 30)
                                                   : $urandom_range(5, 60);
         ready_phase = 0;
      end else begin
         ready_left--;
      end
      ready_phase++;
      case (ready_mode)
         RDY_ALWAYS:      rsp_ready <= 1'b1;
         RDY_RANDOM:      rsp_ready <= ($urandom_range(0, 3) != 0);
         RDY_EVERY_THIRD: rsp_ready <= (ready_phase % 3 == 0);
         default:         rsp_ready <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      indicator_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_indicators.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result transfer macd=%0d signal=%0d hist=%0d",
                           $realtime, rsp_macd_value, rsp_signal_value, rsp_hist_value);
               end
            end else begin
               want = predicted_indicators.pop_front();
               if (rsp_macd_value !== want.macd || rsp_signal_value !== want.signal ||
                   rsp_hist_value !== want.hist) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("%0t: mismatch macd exp=%0d act=%0d signal exp=%0d act=%0d",
                              $realtime, want.macd, rsp_macd_value,
                              want.signal, rsp_signal_value);
                     $display("%0t: mismatch hist exp=%0d act=%0d",
                              $realtime, want.hist, rsp_hist_value);
                  end
               end
            end
         end
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_state();
      test_saturation();
      test_warmup_zero();
      test_warmup_change();
      test_warmup_max();
      test_random_series();
      wait_idle();
      if (error_count == 0 && predicted_indicators.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
